@@ hdl/fcfe_pkg.sv @@
// ---------------------------------------------------------------------------
// fcfe_pkg
// Shared types and constants of the frame cache FIFO evictor.
// ---------------------------------------------------------------------------
package fcfe_pkg;

    localparam int STREAMS     = 4;
    localparam int SLOTS       = 8;
    localparam int DEPTH       = STREAMS * SLOTS;
    localparam int SW          = 2;   // stream index bits
    localparam int PW          = 3;   // slot position bits
    localparam int AW          = SW + PW;
    localparam int CW          = 4;   // fill count bits
    localparam int TAGW        = 24;
    localparam int SIZEW       = 32;
    localparam int HW          = 16;
    localparam int TOTW        = 37;
    localparam int RESW        = 6;
    localparam logic [RESW-1:0] MAX_NOTICES = 6'd32;

    // actions of an input request
    localparam logic [2:0] ACT_STORE   = 3'd0;
    localparam logic [2:0] ACT_EXACT   = 3'd1;
    localparam logic [2:0] ACT_CLOSEST = 3'd2;
    localparam logic [2:0] ACT_CLR_S   = 3'd3;
    localparam logic [2:0] ACT_CLR_ALL = 3'd4;
    localparam logic [2:0] ACT_TRIM    = 3'd5;

    typedef struct packed {
        logic [TAGW-1:0]  tag;
        logic [SIZEW-1:0] size;
        logic [HW-1:0]    handle;
    } entry_t;

    typedef struct packed {
        logic             kind;
        logic             hit;
        logic [SW-1:0]    stream;
        logic [TAGW-1:0]  tag;
        logic [HW-1:0]    handle;
        logic [CW-1:0]    fill;
        logic [TOTW-1:0]  bytes;
        logic             last;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_REPLACE,
        OP_APPEND,
        OP_EV_RD,
        OP_EVICT,
        OP_NEXT_T,
        OP_ZERO,
        OP_STATUS
    } op_t;

    typedef enum logic [1:0] {
        SEL_ITEM,
        SEL_BEST,
        SEL_T
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       scan_more;
        logic       tag_eq;
        logic       lim_full;
        logic       clr_nz;
        logic       t_nz;
        logic       t_last;
        logic       trim_go;
        logic       out_free;
    } stat_t;

endpackage

@@ hdl/fcfe_ctrl.sv @@
// ---------------------------------------------------------------------------
// fcfe_ctrl
// Sequencer for store, lookup, clear and trim requests.
// ---------------------------------------------------------------------------
module fcfe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fcfe_pkg::stat_t st,
    output fcfe_pkg::cmd_t  cmd
);
    import fcfe_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DISP = 13'b0000000000010,
        S_SRD  = 13'b0000000000100,
        S_SCMP = 13'b0000000001000,
        S_REPL = 13'b0000000010000,
        S_LIM  = 13'b0000000100000,
        S_APP  = 13'b0000001000000,
        S_TRIM = 13'b0000010000000,
        S_EV   = 13'b0000100000000,
        S_CLR  = 13'b0001000000000,
        S_CALL = 13'b0010000000000,
        S_ZERO = 13'b0100000000000,
        S_STAT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // next state and command
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = SEL_ITEM;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (st.action)
                    ACT_STORE, ACT_EXACT, ACT_CLOSEST: state_next = S_SRD;
                    ACT_CLR_S:   state_next = S_CLR;
                    ACT_CLR_ALL: state_next = S_CALL;
                    ACT_TRIM:    state_next = S_TRIM;
                    default:     state_next = S_STAT;
                endcase
            end
            S_SRD: begin
                if (st.scan_more) begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCMP;
                end else if (st.action == ACT_STORE) begin
                    state_next = S_LIM;
                end else begin
                    state_next = S_STAT;
                end
            end
            S_SCMP: begin
                cmd.op = OP_SCAN_CMP;
                if (st.tag_eq && st.action == ACT_STORE) begin
                    state_next = S_REPL;
                end else if (st.tag_eq && st.action == ACT_EXACT) begin
                    state_next = S_STAT;
                end else begin
                    state_next = S_SRD;
                end
            end
            S_REPL: begin
                if (st.out_free) begin
                    cmd.op     = OP_REPLACE;
                    state_next = S_STAT;
                end
            end
            S_LIM: begin
                if (st.lim_full) begin
                    cmd.op     = OP_EV_RD;
                    state_next = S_EV;
                    ret_next   = S_LIM;
                end else begin
                    state_next = S_APP;
                end
            end
            S_APP: begin
                cmd.op     = OP_APPEND;
                state_next = S_TRIM;
            end
            S_TRIM: begin
                if (st.trim_go) begin
                    cmd.op     = OP_EV_RD;
                    cmd.sel    = SEL_BEST;
                    state_next = S_EV;
                    ret_next   = S_TRIM;
                end else begin
                    state_next = S_STAT;
                end
            end
            S_EV: begin
                if (st.out_free) begin
                    cmd.op     = OP_EVICT;
                    state_next = ret_reg;
                end
            end
            S_CLR: begin
                if (st.clr_nz) begin
                    cmd.op     = OP_EV_RD;
                    state_next = S_EV;
                    ret_next   = S_CLR;
                end else begin
                    state_next = S_STAT;
                end
            end
            S_CALL: begin
                if (st.t_nz) begin
                    cmd.op     = OP_EV_RD;
                    cmd.sel    = SEL_T;
                    state_next = S_EV;
                    ret_next   = S_CALL;
                end else if (st.t_last) begin
                    state_next = S_ZERO;
                end else begin
                    cmd.op = OP_NEXT_T;
                end
            end
            S_ZERO: begin
                cmd.op     = OP_ZERO;
                state_next = S_STAT;
            end
            S_STAT: begin
                if (st.out_free) begin
                    cmd.op     = OP_STATUS;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

@@ hdl/fcfe_datapath.sv @@
// ---------------------------------------------------------------------------
// fcfe_datapath
// Entry memory, stream rings, byte total and the result register.
// ---------------------------------------------------------------------------
module fcfe_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fcfe_pkg::cmd_t             cmd,
    output fcfe_pkg::stat_t            st,
    input  logic [79:0]                s_tdata,
    input  logic [3:0]                 lim_cfg,
    input  logic [fcfe_pkg::TOTW-1:0]  budget_cfg,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output fcfe_pkg::result_t          res
);
    import fcfe_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    logic [2:0]       act_reg;
    logic [SW-1:0]    s_reg;
    logic [TAGW-1:0]  tag_reg;
    logic [SIZEW-1:0] bytes_reg;
    logic [HW-1:0]    handle_reg;

    logic [PW-1:0]    heads_reg [STREAMS];
    logic [PW-1:0]    heads_next [STREAMS];
    logic [CW-1:0]    counts_reg [STREAMS];
    logic [CW-1:0]    counts_next [STREAMS];
    logic [TOTW-1:0]  total_reg, total_next;
    logic [CW-1:0]    i_reg;
    logic [SW-1:0]    t_reg;
    logic [SW-1:0]    ev_reg;
    logic [AW-1:0]    k_reg;
    logic [RESW-1:0]  resn_reg;
    logic             hit_reg;
    logic [TAGW-1:0]  best_d_reg;
    logic [TAGW-1:0]  ft_reg;
    logic [HW-1:0]    fh_reg;
    logic             out_valid_reg;
    result_t          out_reg, out_next;
    logic             emit;

    logic [CW-1:0]    lim_eff;
    logic [SW-1:0]    best;
    logic [CW-1:0]    best_n;
    logic [SW-1:0]    ev_s;
    logic [AW-1:0]    scan_addr, app_addr, ev_addr;
    logic [TAGW-1:0]  tag_gap;
    entry_t           new_entry;

    // limit clamped to one..slots
    always_comb begin
        if (lim_cfg == '0)
            lim_eff = CW'(1);
        else if (lim_cfg > CW'(SLOTS))
            lim_eff = CW'(SLOTS);
        else
            lim_eff = lim_cfg;
    end

    // fullest stream, lowest index on ties
    always_comb begin
        best   = '0;
        best_n = '0;
        for (int s = 0; s < STREAMS; s++) begin
            if (counts_reg[s] > best_n) begin
                best_n = counts_reg[s];
                best   = SW'(s);
            end
        end
    end

    // slot addresses
    always_comb begin
        case (cmd.sel)
            SEL_BEST: ev_s = best;
            SEL_T:    ev_s = t_reg;
            default:  ev_s = s_reg;
        endcase
        scan_addr = {s_reg, heads_reg[s_reg] + i_reg[PW-1:0]};
        app_addr  = {s_reg, heads_reg[s_reg] + counts_reg[s_reg][PW-1:0]};
        ev_addr   = {ev_s, heads_reg[ev_s]};
        tag_gap   = (rdata_reg.tag >= tag_reg) ? rdata_reg.tag - tag_reg
                                               : tag_reg - rdata_reg.tag;
        new_entry = '{tag: tag_reg, size: bytes_reg, handle: handle_reg};
    end

    // status to the controller
    always_comb begin
        st.action    = act_reg;
        st.scan_more = i_reg < counts_reg[s_reg];
        st.tag_eq    = rdata_reg.tag == tag_reg;
        st.lim_full  = counts_reg[s_reg] >= lim_eff;
        st.clr_nz    = counts_reg[s_reg] != '0;
        st.t_nz      = counts_reg[t_reg] != '0;
        st.t_last    = t_reg == SW'(STREAMS - 1);
        st.trim_go   = (total_reg > budget_cfg) && (resn_reg < MAX_NOTICES)
                       && (best_n != '0);
        st.out_free  = !out_valid_reg || m_tready;
    end

    // ring, total and result updates
    always_comb begin
        heads_next  = heads_reg;
        counts_next = counts_reg;
        total_next  = total_reg;
        emit        = 1'b0;
        out_next    = out_reg;
        case (cmd.op)
            OP_LOAD: total_next = total_reg;
            OP_REPLACE: begin
                total_next = total_reg - TOTW'(rdata_reg.size) + TOTW'(bytes_reg);
                emit       = 1'b1;
            end
            OP_APPEND: begin
                counts_next[s_reg] = counts_reg[s_reg] + CW'(1);
                total_next         = total_reg + TOTW'(bytes_reg);
            end
            OP_EVICT: begin
                heads_next[ev_reg]  = heads_reg[ev_reg] + PW'(1);
                counts_next[ev_reg] = counts_reg[ev_reg] - CW'(1);
                total_next          = total_reg - TOTW'(rdata_reg.size);
                emit                = 1'b1;
            end
            OP_ZERO: total_next = '0;
            OP_STATUS: emit = 1'b1;
            default: total_next = total_reg;
        endcase
        if (emit) begin
            out_next.kind   = cmd.op == OP_STATUS;
            out_next.hit    = (cmd.op == OP_STATUS) && hit_reg;
            out_next.last   = cmd.op == OP_STATUS;
            out_next.fill   = counts_next[s_reg];
            out_next.bytes  = total_next;
            case (cmd.op)
                OP_REPLACE: begin
                    out_next.stream = s_reg;
                    out_next.tag    = tag_reg;
                    out_next.handle = rdata_reg.handle;
                end
                OP_EVICT: begin
                    out_next.stream = ev_reg;
                    out_next.tag    = rdata_reg.tag;
                    out_next.handle = rdata_reg.handle;
                end
                default: begin
                    out_next.stream = hit_reg ? s_reg : '0;
                    out_next.tag    = ft_reg;
                    out_next.handle = fh_reg;
                end
            endcase
        end
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_APPEND)
            mem[app_addr] <= new_entry;
        else if (cmd.op == OP_REPLACE)
            mem[k_reg] <= new_entry;
        if (cmd.op == OP_SCAN_RD)
            rdata_reg <= mem[scan_addr];
        else if (cmd.op == OP_EV_RD)
            rdata_reg <= mem[ev_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STREAMS; s++) begin
                heads_reg[s]  <= '0;
                counts_reg[s] <= '0;
            end
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_STORE;
            i_reg         <= '0;
            t_reg         <= '0;
            resn_reg      <= '0;
            hit_reg       <= 1'b0;
        end else begin
            heads_reg  <= heads_next;
            counts_reg <= counts_next;
            total_reg  <= total_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_LOAD: begin
                    act_reg  <= s_tdata[2:0];
                    i_reg    <= '0;
                    t_reg    <= '0;
                    resn_reg <= '0;
                    hit_reg  <= 1'b0;
                end
                OP_SCAN_CMP: begin
                    i_reg <= i_reg + CW'(1);
                    if ((act_reg == ACT_EXACT && st.tag_eq) ||
                        (act_reg == ACT_CLOSEST && (!hit_reg || tag_gap < best_d_reg)))
                        hit_reg <= 1'b1;
                end
                OP_NEXT_T: t_reg <= t_reg + SW'(1);
                OP_EVICT:  resn_reg <= resn_reg + RESW'(1);
                default:   i_reg <= i_reg;
            endcase
        end
    end

    // request payload and search results
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        case (cmd.op)
            OP_LOAD: begin
                s_reg      <= s_tdata[4:3];
                tag_reg    <= s_tdata[28:5];
                bytes_reg  <= s_tdata[60:29];
                handle_reg <= s_tdata[76:61];
                ft_reg     <= '0;
                fh_reg     <= '0;
                best_d_reg <= '0;
            end
            OP_SCAN_RD: k_reg <= scan_addr;
            OP_SCAN_CMP: begin
                if ((act_reg == ACT_EXACT && st.tag_eq) ||
                    (act_reg == ACT_CLOSEST && (!hit_reg || tag_gap < best_d_reg))) begin
                    ft_reg     <= rdata_reg.tag;
                    fh_reg     <= rdata_reg.handle;
                    best_d_reg <= tag_gap;
                end
            end
            OP_EV_RD: ev_reg <= ev_s;
            default: k_reg <= k_reg;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

`ifndef ASSERT_OFF
    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");
    // fill counts stay within the ring
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg[0] <= CW'(SLOTS) && counts_reg[1] <= CW'(SLOTS) &&
        counts_reg[2] <= CW'(SLOTS) && counts_reg[3] <= CW'(SLOTS))
        else $error("stream fill beyond slots");
    // notice count never exceeds the cap
    a_notice_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        resn_reg <= MAX_NOTICES)
        else $error("too many notices");
    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("result valid after reset");
`endif

endmodule

@@ hdl/frame_cache_fifo_evictor.sv @@
// ---------------------------------------------------------------------------
// frame_cache_fifo_evictor
// Per-stream FIFO cache of frame tags with a global byte budget.
// ---------------------------------------------------------------------------
// A request on the s_ channel carries an action, a stream, a frame tag, a
// byte size and a handle. Each request gives zero or more freed-handle
// notices (tuser 0) and then one status (tuser 1, tlast high) on m_.
// Requests are taken one at a time: s_tready is high only while the block
// is idle, and may be high while the last status still waits on m_.
// Each slot scanned takes a read and a compare through the entry memory
// read port, and each eviction a read and an evict; a store also checks
// the frame limit, appends and checks the byte budget. A new request is
// taken only in the idle state, after the status of the last one has
// been issued. The registers lie on the APB port: frame limit at 0, byte
// budget at 8; write them only while idle.
// Reset empties every stream and zeroes the byte total; entry memory is
// not cleared, only entries inside a stream's fill are ever read.
// While a result waits with m_tready low, the sequencer holds before the next.
// ---------------------------------------------------------------------------
module frame_cache_fifo_evictor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // action, stream_index, frame_tag, frame_bytes, frame_handle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // hit, out_stream, out_tag, out_handle, stream_fill,
                                   // bytes_in_use
    output logic [0:0]  m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import fcfe_pkg::*;

    cmd_t            cmd;
    stat_t           st;
    result_t         res;
    logic [3:0]      lim_reg;
    logic [TOTW-1:0] budget_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg    <= 4'd8;
            budget_reg <= '1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3])
                budget_reg <= pwdata[TOTW-1:0];
            else
                lim_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? {27'd0, budget_reg} : {60'd0, lim_reg};

    fcfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fcfe_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .s_tdata    (s_tdata),
        .lim_cfg    (lim_reg),
        .budget_cfg (budget_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res        (res)
    );

    // result packing
    assign m_tdata = {4'd0, res.bytes, res.fill, res.handle, res.tag, res.stream, res.hit};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
